@@ rtl/spd_pkg.sv @@
package spd_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int STEP_BITS   = 32;
    localparam int RATIO_BITS  = 32;
    localparam int WIN_LEN     = 11;
    localparam int HIST_LEN    = 3;
    localparam int COEF_W      = 12;
    localparam int ACC_W       = SAMPLE_BITS + COEF_W;
    localparam int TAP_W       = $clog2(WIN_LEN);
    localparam int FILL_W      = $clog2(WIN_LEN + 1);
    localparam int CNT_W       = $clog2(HIST_LEN + 1);
    localparam int DIV_STEPS   = RATIO_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_LEN);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(HIST_LEN);
    localparam logic [TAP_W-1:0]  TAP_LAST  = TAP_W'(WIN_LEN - 1);

    typedef enum logic [1:0] {
        REG_ENABLE     = 2'd0,
        REG_RATIO_REAL = 2'd1,
        REG_RATIO_DISC = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_UPD,
        S_CHK,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] velocity;
        logic [STEP_BITS-1:0]          time_step;
    } t_in;

    typedef struct packed {
        logic                  valid_res;
        logic [STEP_BITS-1:0]  period;
        logic [RATIO_BITS-1:0] strouhal_real;
        logic [RATIO_BITS-1:0] strouhal_discrete;
        logic                  rising;
    } t_out;

    typedef struct packed {
        logic shift;
        logic step;
    } t_mac_ctl;

    // smooth differentiator weights, oldest tap first
    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        c = '0;
        case (idx)
            4'd0:    c = COEF_W'(11);
            4'd1:    c = COEF_W'(32);
            4'd2:    c = -COEF_W'(39);
            4'd3:    c = -COEF_W'(256);
            4'd4:    c = -COEF_W'(322);
            4'd6:    c = COEF_W'(322);
            4'd7:    c = COEF_W'(256);
            4'd8:    c = COEF_W'(39);
            4'd9:    c = -COEF_W'(32);
            4'd10:   c = -COEF_W'(11);
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/spd_window_mac.sv @@
module spd_window_mac
    import spd_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mac_ctl                      i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [ACC_W-1:0]       o_acc,
    output logic                          o_last
);

    logic signed [SAMPLE_BITS-1:0] r_win [WIN_LEN];
    logic [TAP_W-1:0]              r_k;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       prod;

    assign prod   = ACC_W'(r_win[r_k]) * ACC_W'(tap_coef(r_k));
    assign o_acc  = r_acc;
    assign o_last = (r_k == TAP_LAST);

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WIN_LEN-1] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_ctl.shift) begin
            r_k <= '0;
        end else if (i_ctl.step && !o_last) begin
            r_k <= r_k + TAP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_acc <= '0;
        end else if (i_ctl.step) begin
            r_acc <= r_acc + prod;
        end
    end

endmodule

@@ rtl/spd_divider.sv @@
module spd_divider
    import spd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [STEP_BITS-1:0]  i_divisor,
    input  logic [RATIO_BITS-1:0] i_dvd_a,
    input  logic [RATIO_BITS-1:0] i_dvd_b,
    output logic                  o_done,
    output logic [RATIO_BITS-1:0] o_quo_a,
    output logic [RATIO_BITS-1:0] o_quo_b
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [RATIO_BITS:0]   r_div;
    logic [RATIO_BITS:0]   r_rem [2];
    logic [RATIO_BITS-1:0] r_quo [2];
    logic [RATIO_BITS:0]   n_rem [2];
    logic [RATIO_BITS-1:0] n_quo [2];
    logic [RATIO_BITS:0]   rem_sh [2];

    // restoring division, one quotient bit per lane per cycle, shared divisor
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            rem_sh[l] = {r_rem[l][RATIO_BITS-1:0], r_quo[l][RATIO_BITS-1]};
            if (rem_sh[l] >= r_div) begin
                n_rem[l] = rem_sh[l] - r_div;
                n_quo[l] = {r_quo[l][RATIO_BITS-2:0], 1'b1};
            end else begin
                n_rem[l] = rem_sh[l];
                n_quo[l] = {r_quo[l][RATIO_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div    <= (RATIO_BITS + 1)'(i_divisor);
            r_rem[0] <= '0;
            r_rem[1] <= '0;
            r_quo[0] <= i_dvd_a;
            r_quo[1] <= i_dvd_b;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done  = r_done;
    assign o_quo_a = r_quo[0];
    assign o_quo_b = r_quo[1];

endmodule

@@ rtl/shedding_period_detector_unit.sv @@
// path: IDLE to OUT when disabled, IDLE to CHK to OUT while the window fills,
// IDLE, MAC, UPD, CHK, OUT when the window is full and the crossing history is not,
// and DIV before OUT once the history is full (shared tap multiply-accumulate, 32-step divider)
// throughput: one item at a time, next input taken in the cycle after the result transfer
// reset: synchronous active-low, clears fill and crossing counts, slope flag and registers
module shedding_period_detector_unit
    import spd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [RATIO_BITS-1:0] i_cfg_data
);

    t_state                r_state;
    t_state                n_state;
    logic                  r_enable;
    logic [RATIO_BITS-1:0] r_ratio_real;
    logic [RATIO_BITS-1:0] r_ratio_disc;
    logic [FILL_W-1:0]     r_fill;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_rising;
    logic [STEP_BITS-1:0]  r_ts;
    logic [STEP_BITS-1:0]  r_hist [HIST_LEN];
    logic [STEP_BITS-1:0]  r_period;
    t_out                  r_out;

    t_mac_ctl                mac_ctl;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_last;
    logic                    div_start;
    logic                    div_done;
    logic [RATIO_BITS-1:0]   quo_a;
    logic [RATIO_BITS-1:0]   quo_b;
    logic                    in_xfer;
    logic                    up;
    logic [STEP_BITS-1:0]    period;

    assign in_xfer = i_in_valid && o_in_ready;
    assign up      = (mac_acc != '0) && !mac_acc[ACC_W-1];
    assign period  = r_hist[HIST_LEN-1] - r_hist[0];

    spd_window_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_sample (i_in_data.velocity),
        .o_acc    (mac_acc),
        .o_last   (mac_last)
    );

    spd_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (period),
        .i_dvd_a   (r_ratio_real),
        .i_dvd_b   (r_ratio_disc),
        .o_done    (div_done),
        .o_quo_a   (quo_a),
        .o_quo_b   (quo_b)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!r_enable) begin
                        n_state = S_OUT;
                    end else if (r_fill != FILL_FULL) begin
                        n_state = S_CHK;
                    end else begin
                        n_state = S_MAC;
                    end
                end
            end
            S_MAC: begin
                if (mac_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: n_state = S_CHK;
            S_CHK: begin
                n_state = (r_cnt == CNT_FULL) ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        mac_ctl.shift = 1'b0;
        mac_ctl.step  = 1'b0;
        div_start     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                mac_ctl.shift = i_in_valid && r_enable;
            end
            S_MAC: mac_ctl.step = 1'b1;
            S_CHK: div_start = (r_cnt == CNT_FULL);
            S_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_ratio_real <= '0;
            r_ratio_disc <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLE:     r_enable     <= i_cfg_data[0];
                REG_RATIO_REAL: r_ratio_real <= i_cfg_data;
                REG_RATIO_DISC: r_ratio_disc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_cnt    <= '0;
            r_rising <= 1'b0;
        end else begin
            if (in_xfer && r_enable && r_fill != FILL_FULL) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (r_state == S_UPD && up != r_rising) begin
                r_rising <= up;
                if (r_cnt != CNT_FULL) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    // crossing history shifts toward the oldest entry
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ts <= i_in_data.time_step;
        end
        if (r_state == S_UPD && up != r_rising) begin
            for (int i = 0; i < HIST_LEN - 1; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
            r_hist[HIST_LEN-1] <= r_ts;
        end
        if (div_start) begin
            r_period <= period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_xfer && !r_enable) begin
            r_out <= '{valid_res: 1'b0, period: '0, strouhal_real: '0,
                       strouhal_discrete: '0, rising: r_rising};
        end else if (r_state == S_CHK && r_cnt != CNT_FULL) begin
            r_out <= '{valid_res: 1'b0, period: '0, strouhal_real: '0,
                       strouhal_discrete: '0, rising: r_rising};
        end else if (r_state == S_DIV && div_done) begin
            r_out <= '{valid_res: 1'b1, period: r_period, strouhal_real: quo_a,
                       strouhal_discrete: quo_b, rising: r_rising};
        end
    end

    assign o_out_data = r_out;

`ifndef NO_ASSERTIONS
    a_no_input_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while a result is pending");

    a_valid_needs_full_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.valid_res) |-> (r_cnt == CNT_FULL))
        else $error("valid result without full crossing history");

    a_disabled_goes_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !r_enable) |=> (r_state == S_OUT))
        else $error("disabled item did not go straight to result");

    a_fill_only_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_fill == $past(r_fill)))
        else $error("window fill changed outside an input transfer");

    a_div_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_enable && r_fill == FILL_FULL))
        else $error("divider started before window filled");
`endif

endmodule

@@ tb/shedding_period_detector_unit_tb.sv @@
`timescale 1ns / 100ps

module shedding_period_detector_unit_tb;
    import spd_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int OUT_HOLD_CYCLES = 400;
    localparam int NUM_PHASES      = 10;
    localparam int DIR_LEN         = 25;
    localparam int EXP_DEPTH       = 64;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [31:0] VMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VMIN = 32'h8000_0000;
    localparam logic [31:0] VMID = 32'h0123_4567;
    localparam logic [31:0] TMAX = 32'hFFFF_FFFF;
    localparam logic [31:0] RMAX = 32'hFFFF_FFFF;
    localparam t_out        QUIET = '0;

    typedef struct packed {
        logic        apply_cfg;
        logic        en;
        logic [31:0] ratio_r;
        logic [31:0] ratio_d;
        t_in         smp;
        logic        typed;
        t_out        want;
    } t_dir_row;

    // disabled after reset, window fill, zero slope sum, extremes, wrapped and zero periods
    localparam t_dir_row DIR_ROWS [DIR_LEN] = '{
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMAX, 32'd0}, 1'b1, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMIN, TMAX}, 1'b1, QUIET},
        '{1'b1, 1'b1, RMAX, 32'h0, '{VMID, 32'd10}, 1'b1, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMID, 32'd11}, 1'b1, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMID, 32'd12}, 1'b1, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMID, 32'd13}, 1'b1, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMID, 32'd14}, 1'b1, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMID, 32'd15}, 1'b1, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMID, 32'd16}, 1'b1, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMID, 32'd17}, 1'b1, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMID, 32'd18}, 1'b1, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMID, 32'd19}, 1'b1, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMID, 32'd20}, 1'b1, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMID, 32'd21}, 1'b0, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMAX, 32'd30}, 1'b0, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMIN, 32'd40}, 1'b0, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMIN, 32'd50}, 1'b0, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMIN, 32'd60}, 1'b0, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMAX, TMAX - 32'd5}, 1'b0, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMAX, TMAX}, 1'b0, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMAX, 32'd3}, 1'b0, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMIN, 32'd3}, 1'b0, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMIN, 32'd3}, 1'b0, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMIN, 32'd3}, 1'b0, QUIET},
        '{1'b0, 1'b0, 32'h0, 32'h0, '{VMAX, 32'd3}, 1'b0, QUIET}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index;
    logic [RATIO_BITS-1:0] i_cfg_data;

    shedding_period_detector_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    longint                model_win [WIN_LEN];
    int                    model_fill = 0;
    logic                  model_rising = 1'b0;
    logic [STEP_BITS-1:0]  model_cross [HIST_LEN];
    int                    model_cross_cnt = 0;
    logic                  model_enable = 1'b0;
    logic [RATIO_BITS-1:0] model_ratio_r = '0;
    logic [RATIO_BITS-1:0] model_ratio_d = '0;

    // expected results, ring of EXP_DEPTH entries
    t_out expected_reports [EXP_DEPTH];
    int   exp_wr = 0;
    int   exp_rd = 0;
    t_out got_report;
    t_out want_report;
    int   fail_cnt = 0;
    int   cycle_cnt = 0;
    bit   hold_out_req = 1'b0;
    bit   in_calm = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("** shedding_period_detector_unit: FAILED **");
        $finish;
    end

    function automatic logic [RATIO_BITS-1:0] strouhal_of(input logic [RATIO_BITS-1:0] ratio,
                                                         input logic [STEP_BITS-1:0] span);
        if (span == '0)
            return '1;
        return ratio / span;
    endfunction

    function automatic t_out predict_shedding(input t_in smp);
        t_out   res;
        longint acc;
        logic   now_up;
        logic [STEP_BITS-1:0] span;
        int     k;
        res = '0;
        if (model_enable) begin
            if (model_fill < WIN_LEN) begin
                model_win[model_fill] = longint'($signed(smp.velocity));
                model_fill++;
            end else begin
                for (k = 0; k < WIN_LEN - 1; k++)
                    model_win[k] = model_win[k + 1];
                model_win[WIN_LEN - 1] = longint'($signed(smp.velocity));
                acc = 322 * (model_win[6] - model_win[4])
                    + 256 * (model_win[7] - model_win[3])
                    + 39 * (model_win[8] - model_win[2])
                    - 32 * (model_win[9] - model_win[1])
                    - 11 * (model_win[10] - model_win[0]);
                now_up = (acc > 0);
                if (now_up != model_rising) begin
                    model_rising = now_up;
                    if (model_cross_cnt < HIST_LEN) begin
                        model_cross[model_cross_cnt] = smp.time_step;
                        model_cross_cnt++;
                    end else begin
                        model_cross[0] = model_cross[1];
                        model_cross[1] = model_cross[2];
                        model_cross[2] = smp.time_step;
                    end
                end
            end
            if (model_cross_cnt == HIST_LEN) begin
                span = model_cross[2] - model_cross[0];
                res.valid_res         = 1'b1;
                res.period            = span;
                res.strouhal_real     = strouhal_of(model_ratio_r, span);
                res.strouhal_discrete = strouhal_of(model_ratio_d, span);
            end
        end
        res.rising = model_rising;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (in_calm || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // valid stays high across back-to-back transfers, lowered only for a gap or while draining results
    task automatic send_sample(input t_in smp, input logic typed, input t_out want);
        int   gap;
        t_out pred;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= smp;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pred = predict_shedding(smp);
        expected_reports[exp_wr % EXP_DEPTH] = typed ? want : pred;
        exp_wr++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [RATIO_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            REG_ENABLE:     model_enable  = data[0];
            REG_RATIO_REAL: model_ratio_r = data;
            REG_RATIO_DISC: model_ratio_d = data;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_report = o_out_data;
            if (exp_wr == exp_rd) begin
                $display("%0t: unexpected result %h", $time, got_report);
                fail_cnt++;
            end else begin
                want_report = expected_reports[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got_report.valid_res != want_report.valid_res) begin
                    $display("%0t: valid_res expected %h actual %h", $time,
                             want_report.valid_res, got_report.valid_res);
                    fail_cnt++;
                end
                if (got_report.period != want_report.period) begin
                    $display("%0t: period expected %h actual %h", $time,
                             want_report.period, got_report.period);
                    fail_cnt++;
                end
                if (got_report.strouhal_real != want_report.strouhal_real) begin
                    $display("%0t: strouhal_real expected %h actual %h", $time,
                             want_report.strouhal_real, got_report.strouhal_real);
                    fail_cnt++;
                end
                if (got_report.strouhal_discrete != want_report.strouhal_discrete) begin
                    $display("%0t: strouhal_discrete expected %h actual %h", $time,
                             want_report.strouhal_discrete, got_report.strouhal_discrete);
                    fail_cnt++;
                end
                if (got_report.rising != want_report.rising) begin
                    $display("%0t: rising expected %h actual %h", $time,
                             want_report.rising, got_report.rising);
                    fail_cnt++;
                end
            end
        end
    end

    // result receiver with random back-pressure
    initial begin
        int burst;
        int stall;
        int r;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_out_req) begin
                hold_out_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (OUT_HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            r = $urandom_range(0, 99);
            burst = (r < 10) ? $urandom_range(100, 300) : $urandom_range(1, 20);
            repeat (burst) @(posedge i_clk);
            r = $urandom_range(0, 99);
            stall = (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 4) : $urandom_range(10, 40);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        int                    row;
        int                    ph;
        int                    k;
        int                    n_items;
        int                    r;
        int                    wave_dir;
        int                    wave_step;
        int                    wave_left;
        int                    freeze_left;
        logic                  en;
        logic signed [31:0]    wave_lvl;
        logic [STEP_BITS-1:0]  ts_now;
        logic [RATIO_BITS-1:0] rr;
        logic [RATIO_BITS-1:0] rd;
        logic [RATIO_BITS-1:0] word;
        t_in                   smp;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        for (k = 0; k < WIN_LEN; k++)
            model_win[k] = 0;
        for (k = 0; k < HIST_LEN; k++)
            model_cross[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < DIR_LEN; row++) begin
            if (DIR_ROWS[row].apply_cfg) begin
                drain_results();
                write_reg(REG_ENABLE, RATIO_BITS'(DIR_ROWS[row].en));
                write_reg(REG_RATIO_REAL, DIR_ROWS[row].ratio_r);
                write_reg(REG_RATIO_DISC, DIR_ROWS[row].ratio_d);
                i_cfg_valid <= 1'b0;
            end
            send_sample(DIR_ROWS[row].smp, DIR_ROWS[row].typed, DIR_ROWS[row].want);
        end

        ts_now      = 32'd1000;
        wave_lvl    = '0;
        wave_dir    = 1;
        wave_left   = 0;
        freeze_left = 0;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            en = (ph != 5);
            case (ph)
                0: begin rr = '0; rd = RMAX; end
                1: begin rr = RMAX; rd = '0; end
                default: begin
                    r = $urandom_range(0, 2);
                    if (r == 0) begin
                        rr = $urandom();
                        rd = $urandom();
                    end else if (r == 1) begin
                        rr = RATIO_BITS'($urandom_range(1, 2000)) << 16;
                        rd = RATIO_BITS'($urandom_range(1, 2000)) << 16;
                    end else begin
                        rr = $urandom_range(0, 5000);
                        rd = RMAX - $urandom_range(0, 5000);
                    end
                end
            endcase
            word = $urandom();
            word[0] = en;
            write_reg(REG_ENABLE, word);
            write_reg(REG_RATIO_REAL, rr);
            write_reg(REG_RATIO_DISC, rd);
            if (ph == 3)
                write_reg(REG_UNUSED, $urandom());
            i_cfg_valid <= 1'b0;

            in_calm   = (ph == 2) || ($urandom_range(0, 4) == 0);
            wave_step = (ph == 7) ? $urandom_range(1 << 26, 1 << 28) : $urandom_range(1, 1 << 22);
            n_items   = en ? 204 : 60;
            for (k = 0; k < n_items; k++) begin
                if (ph == 1 && k == 60)
                    hold_out_req = 1'b1;
                if (ph == 6 && k == 100)
                    drain_results();
                if ($urandom_range(0, 99) < 85) begin
                    if (wave_left == 0) begin
                        wave_dir  = -wave_dir;
                        wave_left = $urandom_range(2, 9);
                    end
                    wave_left--;
                    wave_lvl = wave_lvl + 32'(wave_dir * wave_step)
                             + 32'($urandom_range(0, 15)) - 32'sd8;
                    smp.velocity = wave_lvl;
                end else begin
                    smp.velocity = $urandom();
                end
                // frozen step count gives zero periods
                if (freeze_left > 0) begin
                    freeze_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        freeze_left = $urandom_range(12, 30);
                    else if (r < 6)
                        ts_now = $urandom();
                    else
                        ts_now = ts_now + STEP_BITS'($urandom_range(1, 40));
                end
                smp.time_step = ts_now;
                send_sample(smp, 1'b0, QUIET);
            end
        end

        drain_results();
        if (fail_cnt == 0)
            $display("** shedding_period_detector_unit: PASSED **");
        else
            $display("** shedding_period_detector_unit: FAILED **");
        $finish;
    end

endmodule
